// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the chunk loss tracker.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/clt_pkg.sv
// Package for the chunk loss tracker: sizes, codes and transaction types.
// No dependencies.
`timescale 1ns / 1ps
package clt_pkg;

    localparam int MAX_CHUNKS = 4096;
    localparam int SEQ_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = 13;
    localparam int ROW_W      = 32;
    localparam int BIT_W      = $clog2(ROW_W);
    localparam int ROWS       = MAX_CHUNKS / ROW_W;
    localparam int ROW_AW     = SEQ_W - BIT_W;
    localparam int ROW_CNT_W  = $clog2(ROW_W + 1);

    localparam logic [1:0] MODE_CHUNK    = 2'd0;
    localparam logic [1:0] MODE_DEADLINE = 2'd1;
    localparam logic [1:0] MODE_START    = 2'd2;

    localparam logic [3:0] V_NEW        = 4'd0;
    localparam logic [3:0] V_RECOVERED  = 4'd1;
    localparam logic [3:0] V_DUP_LATEST = 4'd2;
    localparam logic [3:0] V_DUP_OLD    = 4'd3;
    localparam logic [3:0] V_RANGE      = 4'd4;
    localparam logic [3:0] V_DONE       = 4'd5;
    localparam logic [3:0] V_TAIL       = 4'd6;
    localparam logic [3:0] V_NO_TAIL    = 4'd7;
    localparam logic [3:0] V_STARTED    = 4'd8;

    localparam logic [1:0] REG_CHUNK_SIZE   = 2'd0;
    localparam logic [1:0] REG_TOTAL_CHUNKS = 2'd1;
    localparam logic [1:0] REG_END_SEQUENCE = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] sequence_req;
        logic [15:0] chunk_length;
    } t_item;

    typedef struct packed {
        logic [3:0]       verdict;
        logic             write_enable;
        logic [31:0]      write_offset;
        logic [15:0]      write_length;
        logic [CNT_W-1:0] newly_lost;
        logic [CNT_W-1:0] remaining;
        logic             complete;
    } t_result;

    // Row update control: mark [lo, hi) lost, optionally clear one bit.
    typedef struct packed {
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic             clr_en;
        logic [SEQ_W-1:0] clr_bit;
    } t_row_ctl;

endpackage

// File: src/chunk_loss_tracker.sv
// Top level of the chunk loss tracker: sequencer, registers, bitmap RAM.
// Depends on clt_pkg, clt_ram, clt_row_upd and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel   ports                              transaction taken when
//  --------  ---------------------------------  ----------------------------
//  item in   i_start, o_busy, i_item            i_start high, o_busy low
//  result    o_done, o_result                   o_done high (one cycle only)
//  config    i_cfg_we, i_cfg_idx, i_cfg_data    i_cfg_we high
//
//  Lost bitmap lives in a 128 x 32 RAM; every touched row is read, modified
//  and written back, one row per cycle (read of row n+1 overlaps write of n).
//  In-order chunk or recovery: accept, then one row update.
//  Gap or tail marking: accept, then one update per bitmap row spanned by the window.
//  Start: accept, then the clearing pass over all rows; result at its end.
//  After reset the same clearing pass runs with o_busy high and no
//  result; config writes are taken throughout. Results cannot be stalled.
//
module chunk_loss_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  clt_pkg::t_item    i_item,
    output logic              o_done,
    output clt_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    // kind of bitmap walk in flight
    localparam logic [1:0] K_NEW  = 2'd0;
    localparam logic [1:0] K_REC  = 2'd1;
    localparam logic [1:0] K_TAIL = 2'd2;

    localparam logic [clt_pkg::CNT_W-1:0] MAX_C = clt_pkg::CNT_W'(clt_pkg::MAX_CHUNKS);
    localparam logic [clt_pkg::ROW_AW-1:0] LAST_ROW = clt_pkg::ROW_AW'(clt_pkg::ROWS - 1);

    // configuration
    logic [15:0]               r_cs;
    logic [clt_pkg::CNT_W-1:0] r_total;
    logic [clt_pkg::CNT_W-1:0] r_endseq;

    // control state
    logic [1:0]                  r_state,    n_state;
    logic [clt_pkg::ROW_AW-1:0]  r_row,      n_row;
    logic [clt_pkg::ROW_AW-1:0]  r_last_row, n_last_row;
    logic [1:0]                  r_kind,     n_kind;
    logic                        r_clr_emit, n_clr_emit;
    logic [clt_pkg::CNT_W-1:0]   r_ne,       n_ne;
    logic [clt_pkg::CNT_W-1:0]   r_rem,      n_rem;
    logic                        r_armed,    n_armed;
    logic                        r_done,     n_done;

    // payload
    clt_pkg::t_row_ctl           r_ctl,      n_ctl;
    logic [clt_pkg::CNT_W-1:0]   r_lost_cnt, n_lost_cnt;
    logic [31:0]                 r_offset,   n_offset;
    logic [15:0]                 r_len,      n_len;
    clt_pkg::t_result            r_res,      n_res;

    // RAM and row update
    logic                          rd_en, wr_en;
    logic [clt_pkg::ROW_AW-1:0]    rd_addr, wr_addr;
    logic [clt_pkg::ROW_W-1:0]     wr_data, rd_data, upd_row;
    logic [clt_pkg::ROW_CNT_W-1:0] upd_cnt;

    // decode helpers
    logic [clt_pkg::CNT_W-1:0] lim_to;
    logic [clt_pkg::CNT_W-1:0] to_m1;
    logic [clt_pkg::CNT_W-1:0] seq13;
    logic                      seq_in_rng;
    logic [47:0]               prod;
    logic                      old_bit;

    clt_ram #(
        .DATA_W (clt_pkg::ROW_W),
        .ADDR_W (clt_pkg::ROW_AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    clt_row_upd u_upd (
        .i_ctl (r_ctl),
        .i_row (r_row),
        .i_old (rd_data),
        .o_new (upd_row),
        .o_cnt (upd_cnt)
    );

    // tail bound is the smaller of end_sequence and capacity
    assign lim_to     = (r_endseq > MAX_C) ? MAX_C : r_endseq;
    assign to_m1      = lim_to - clt_pkg::CNT_W'(1);
    assign seq_in_rng = i_item.sequence_req < 32'(clt_pkg::MAX_CHUNKS);
    assign seq13      = clt_pkg::CNT_W'(i_item.sequence_req[clt_pkg::SEQ_W-1:0]);
    assign prod       = 48'(r_cs) * 48'(i_item.sequence_req);
    assign old_bit    = rd_data[r_ctl.clr_bit[clt_pkg::BIT_W-1:0]];

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_last_row = r_last_row;
        n_kind     = r_kind;
        n_clr_emit = r_clr_emit;
        n_ne       = r_ne;
        n_rem      = r_rem;
        n_armed    = r_armed;
        n_done     = 1'b0;
        n_ctl      = r_ctl;
        n_lost_cnt = r_lost_cnt;
        n_offset   = r_offset;
        n_len      = r_len;
        n_res      = r_res;
        rd_en      = 1'b0;
        rd_addr    = clt_pkg::ROW_AW'(r_row + clt_pkg::ROW_AW'(1));
        wr_en      = 1'b0;
        wr_addr    = r_row;
        wr_data    = upd_row;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_offset   = prod[31:0];
                    n_len      = i_item.chunk_length;
                    n_lost_cnt = '0;
                    n_res      = '{verdict: clt_pkg::V_NO_TAIL, write_enable: 1'b0,
                                   write_offset: 32'd0, write_length: 16'd0,
                                   newly_lost: '0, remaining: r_rem,
                                   complete: (r_rem == '0)};
                    unique case (i_item.mode)
                        clt_pkg::MODE_START: begin
                            n_state    = S_CLEAR;
                            n_row      = '0;
                            n_clr_emit = 1'b1;
                        end
                        clt_pkg::MODE_DEADLINE: begin
                            if (r_armed && r_rem != '0) begin
                                n_armed = 1'b0;
                                if (lim_to > r_ne) begin
                                    rd_en      = 1'b1;
                                    rd_addr    = r_ne[clt_pkg::SEQ_W-1:clt_pkg::BIT_W];
                                    n_row      = r_ne[clt_pkg::SEQ_W-1:clt_pkg::BIT_W];
                                    n_last_row = to_m1[clt_pkg::SEQ_W-1:clt_pkg::BIT_W];
                                    n_ctl      = '{lo: r_ne, hi: lim_to, clr_en: 1'b0,
                                                   clr_bit: '0};
                                    n_kind     = K_TAIL;
                                    n_state    = S_WALK;
                                end else begin
                                    // nothing left past the highest seen
                                    n_res.verdict = clt_pkg::V_TAIL;
                                    n_done        = 1'b1;
                                end
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        clt_pkg::MODE_CHUNK: begin
                            priority if (r_rem == '0) begin
                                n_res.verdict = clt_pkg::V_DONE;
                                n_done        = 1'b1;
                            end else if (!seq_in_rng) begin
                                n_res.verdict = clt_pkg::V_RANGE;
                                n_done        = 1'b1;
                            end else if (seq13 >= r_ne) begin
                                // ahead: mark the gap lost, clear own bit
                                rd_en      = 1'b1;
                                rd_addr    = r_ne[clt_pkg::SEQ_W-1:clt_pkg::BIT_W];
                                n_row      = r_ne[clt_pkg::SEQ_W-1:clt_pkg::BIT_W];
                                n_last_row = seq13[clt_pkg::SEQ_W-1:clt_pkg::BIT_W];
                                n_ctl      = '{lo: r_ne, hi: seq13, clr_en: 1'b1,
                                               clr_bit: seq13[clt_pkg::SEQ_W-1:0]};
                                n_kind     = K_NEW;
                                n_state    = S_WALK;
                            end else if (seq13 + clt_pkg::CNT_W'(1) == r_ne) begin
                                n_res.verdict = clt_pkg::V_DUP_LATEST;
                                n_done        = 1'b1;
                            end else begin
                                // older: look up its lost bit
                                rd_en      = 1'b1;
                                rd_addr    = seq13[clt_pkg::SEQ_W-1:clt_pkg::BIT_W];
                                n_row      = seq13[clt_pkg::SEQ_W-1:clt_pkg::BIT_W];
                                n_last_row = seq13[clt_pkg::SEQ_W-1:clt_pkg::BIT_W];
                                n_ctl      = '{lo: '0, hi: '0, clr_en: 1'b1,
                                               clr_bit: seq13[clt_pkg::SEQ_W-1:0]};
                                n_kind     = K_REC;
                                n_state    = S_WALK;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                wr_en      = 1'b1;
                n_lost_cnt = r_lost_cnt + clt_pkg::CNT_W'(upd_cnt);
                if (r_row != r_last_row) begin
                    rd_en = 1'b1;
                    n_row = clt_pkg::ROW_AW'(r_row + clt_pkg::ROW_AW'(1));
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_res   = '{verdict: clt_pkg::V_TAIL, write_enable: 1'b0,
                                write_offset: 32'd0, write_length: 16'd0,
                                newly_lost: n_lost_cnt, remaining: r_rem,
                                complete: (r_rem == '0)};
                    unique case (r_kind)
                        K_NEW: begin
                            n_ne  = clt_pkg::CNT_W'(r_ctl.clr_bit) + clt_pkg::CNT_W'(1);
                            n_rem = r_rem - clt_pkg::CNT_W'(1);
                            n_res.verdict      = clt_pkg::V_NEW;
                            n_res.write_enable = 1'b1;
                            n_res.write_offset = r_offset;
                            n_res.write_length = r_len;
                            n_res.remaining    = n_rem;
                            n_res.complete     = (n_rem == '0);
                        end
                        K_REC: begin
                            if (old_bit) begin
                                n_rem = r_rem - clt_pkg::CNT_W'(1);
                                n_res.verdict      = clt_pkg::V_RECOVERED;
                                n_res.write_enable = 1'b1;
                                n_res.write_offset = r_offset;
                                n_res.write_length = r_len;
                                n_res.remaining    = n_rem;
                                n_res.complete     = (n_rem == '0);
                            end else begin
                                n_res.verdict = clt_pkg::V_DUP_OLD;
                            end
                        end
                        default: begin
                            n_res.verdict = clt_pkg::V_TAIL;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (r_row != LAST_ROW) begin
                    n_row = clt_pkg::ROW_AW'(r_row + clt_pkg::ROW_AW'(1));
                end else begin
                    n_state    = S_IDLE;
                    n_clr_emit = 1'b0;
                    if (r_clr_emit) begin
                        n_ne    = '0;
                        n_rem   = r_total;
                        n_armed = 1'b1;
                        n_done  = 1'b1;
                        n_res   = '{verdict: clt_pkg::V_STARTED, write_enable: 1'b0,
                                    write_offset: 32'd0, write_length: 16'd0,
                                    newly_lost: '0, remaining: r_total,
                                    complete: (r_total == '0)};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers; reset starts the clearing pass without a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_row      <= '0;
            r_last_row <= '0;
            r_kind     <= K_NEW;
            r_clr_emit <= 1'b0;
            r_ne       <= '0;
            r_rem      <= '0;
            r_armed    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_last_row <= n_last_row;
            r_kind     <= n_kind;
            r_clr_emit <= n_clr_emit;
            r_ne       <= n_ne;
            r_rem      <= n_rem;
            r_armed    <= n_armed;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl      <= n_ctl;
        r_lost_cnt <= n_lost_cnt;
        r_offset   <= n_offset;
        r_len      <= n_len;
        r_res      <= n_res;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs     <= 16'd1024;
            r_total  <= '0;
            r_endseq <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                clt_pkg::REG_CHUNK_SIZE:   r_cs     <= i_cfg_data;
                clt_pkg::REG_TOTAL_CHUNKS: r_total  <= i_cfg_data[clt_pkg::CNT_W-1:0];
                clt_pkg::REG_END_SEQUENCE: r_endseq <= i_cfg_data[clt_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // a row is never read in the cycle it is written back
    `ASSERT_CLK(a_no_rw_clash, i_clk, i_rst_n, (rd_en && wr_en) |-> (rd_addr != wr_addr), "RAM read and write hit the same row")
    // the walk never runs past its last row
    `ASSERT_CLK(a_walk_bound, i_clk, i_rst_n, (r_state == S_WALK) |-> (r_row <= r_last_row), "bitmap walk overran its window")
    // only stored chunks carry a write
    `ASSERT_CLK(a_we_verdict, i_clk, i_rst_n, (o_done && o_result.write_enable) |-> (o_result.verdict == clt_pkg::V_NEW || o_result.verdict == clt_pkg::V_RECOVERED), "write strobe on a non-storing verdict")
    // highest-seen mark stays within capacity
    `ASSERT_CLK(a_ne_bound, i_clk, i_rst_n, r_ne <= MAX_C, "next expected beyond capacity")
    // no result while the clearing pass still has rows to go
    `ASSERT_CLK(a_clear_quiet, i_clk, i_rst_n, (r_state == S_CLEAR && r_row != LAST_ROW) |=> !o_done, "result during clearing pass")

endmodule

// File: src/clt_ram.sv
// Simple dual-port synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps
module clt_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/clt_row_upd.sv
// One bitmap row update: marks a sequence window lost, clears one bit,
// counts newly lost bits. Depends on clt_pkg.
`timescale 1ns / 1ps
module clt_row_upd (
    input  clt_pkg::t_row_ctl                i_ctl,
    input  logic [clt_pkg::ROW_AW-1:0]       i_row,
    input  logic [clt_pkg::ROW_W-1:0]        i_old,
    output logic [clt_pkg::ROW_W-1:0]        o_new,
    output logic [clt_pkg::ROW_CNT_W-1:0]    o_cnt
);

    logic [clt_pkg::ROW_W-1:0] set_v;
    logic [clt_pkg::ROW_W-1:0] clr_v;

    always_comb begin
        for (int b = 0; b < clt_pkg::ROW_W; b++) begin
            set_v[b] = (clt_pkg::CNT_W'({i_row, clt_pkg::BIT_W'(b)}) >= i_ctl.lo) &&
                       (clt_pkg::CNT_W'({i_row, clt_pkg::BIT_W'(b)}) <  i_ctl.hi);
            clr_v[b] = i_ctl.clr_en && ({i_row, clt_pkg::BIT_W'(b)} == i_ctl.clr_bit);
        end
    end

    assign o_new = (i_old | set_v) & ~clr_v;
    assign o_cnt = clt_pkg::ROW_CNT_W'($countones(set_v & ~i_old));

endmodule

// File: dv/tb.sv
// Self-checking testbench for chunk_loss_tracker: directed and random transfers.
// Depends on clt_pkg and the chunk_loss_tracker RTL; needs nothing else.
`timescale 1ns / 1ps
module tb;

    // Mode code the block leaves unused; it must behave as a no-op.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1430;
    // Slowest legal item is a start (a clearing pass over all rows) followed by
    // a long sender gap; the limit covers that over the whole run.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 140;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_start    = 1'b0;
    logic              o_busy;
    clt_pkg::t_item    i_item     = '0;
    logic              o_done;
    clt_pkg::t_result  o_result;
    logic              i_cfg_we   = 1'b0;
    logic [1:0]        i_cfg_idx  = clt_pkg::REG_CHUNK_SIZE;
    logic [15:0]       i_cfg_data = '0;

    chunk_loss_tracker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the tracker: lost bitmap, window position, outstanding
    // count, deadline arming and the three registers (reset values).
    // ------------------------------------------------------------------
    bit          lost_bits [clt_pkg::MAX_CHUNKS];
    int unsigned hi_next          = 0;   // one past highest sequence seen
    int unsigned left_cnt         = 0;   // chunks still outstanding
    bit          tail_live        = 1'b0;
    logic [15:0] cfg_chunk_size   = 16'd1024;
    logic [12:0] cfg_total_chunks = '0;
    logic [12:0] cfg_end_sequence = '0;

    clt_pkg::t_result expected_results [$];
    int unsigned fail_cnt   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned items_sent = 0;
    bit          no_idle    = 1'b0;

    // Marks [from, upto) lost, clipped to the bitmap; returns bits newly set.
    function automatic int unsigned mark_lost(input int unsigned from, input int unsigned upto);
        int unsigned n;
        n = 0;
        if (upto > clt_pkg::MAX_CHUNKS)
            upto = clt_pkg::MAX_CHUNKS;
        for (int unsigned k = from; k < upto; k++) begin
            if (!lost_bits[k]) begin
                lost_bits[k] = 1'b1;
                n++;
            end
        end
        return n;
    endfunction

    // Advances the shadow by one transaction and returns the result it owes.
    function automatic clt_pkg::t_result track_chunk(input clt_pkg::t_item it);
        clt_pkg::t_result r;
        logic [31:0]      s;
        int unsigned      marked;
        r         = '0;
        s         = it.sequence_req;
        marked    = 0;
        r.verdict = clt_pkg::V_NO_TAIL;
        case (it.mode)
            clt_pkg::MODE_START: begin
                foreach (lost_bits[k])
                    lost_bits[k] = 1'b0;
                left_cnt  = 32'(cfg_total_chunks);
                hi_next   = 0;
                tail_live = 1'b1;
                r.verdict = clt_pkg::V_STARTED;
            end
            clt_pkg::MODE_DEADLINE: begin
                // tail marking happens at most once per transfer
                if (tail_live && left_cnt != 0) begin
                    marked    = mark_lost(hi_next, 32'(cfg_end_sequence));
                    tail_live = 1'b0;
                    r.verdict = clt_pkg::V_TAIL;
                end
            end
            clt_pkg::MODE_CHUNK: begin
                if (left_cnt == 0) begin
                    r.verdict = clt_pkg::V_DONE;
                end else if (s >= clt_pkg::MAX_CHUNKS) begin
                    r.verdict = clt_pkg::V_RANGE;
                end else if (s >= hi_next) begin
                    // ahead: skipped numbers go lost, own bit cleared even if
                    // tail marking had set it
                    marked         = mark_lost(hi_next, s);
                    lost_bits[s]   = 1'b0;
                    hi_next        = s + 1;
                    left_cnt--;
                    r.write_enable = 1'b1;
                    r.verdict      = clt_pkg::V_NEW;
                end else if (s + 1 == hi_next) begin
                    r.verdict = clt_pkg::V_DUP_LATEST;
                end else if (lost_bits[s]) begin
                    lost_bits[s]   = 1'b0;
                    left_cnt--;
                    r.write_enable = 1'b1;
                    r.verdict      = clt_pkg::V_RECOVERED;
                end else begin
                    r.verdict = clt_pkg::V_DUP_OLD;
                end
            end
            default: ;
        endcase
        if (r.write_enable) begin
            r.write_offset = 32'(cfg_chunk_size) * s;
            r.write_length = it.chunk_length;
        end
        r.newly_lost = (marked > 8191) ? '1 : marked[clt_pkg::CNT_W-1:0];
        r.remaining  = left_cnt[clt_pkg::CNT_W-1:0];
        r.complete   = (left_cnt == 0);
        return r;
    endfunction

    function automatic clt_pkg::t_item make_item(input logic [1:0] mode, input logic [31:0] s,
                                                 input logic [15:0] len);
        clt_pkg::t_item it;
        it.mode         = mode;
        it.sequence_req = s;
        it.chunk_length = len;
        return it;
    endfunction

    // A lost sequence below the window head, or -1 when none is lost.
    function automatic int pick_lost();
        int found [$];
        for (int k = 0; k < int'(hi_next); k++)
            if (lost_bits[k])
                found.push_back(k);
        if (found.size() == 0)
            return -1;
        return found[$urandom_range(0, found.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit, result checking
    // ------------------------------------------------------------------
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** chunk_loss_tracker: FAILED **");
            $finish;
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // Outputs are sampled mid-cycle, away from the edge that moves them; a
    // strobe lasts one cycle so each result is seen exactly once here.
    always @(negedge i_clk) begin
        clt_pkg::t_result want;
        if (o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: verdict %0d",
                       o_result.verdict);
                fail_cnt++;
            end else begin
                want = expected_results.pop_front();
                check_field("verdict", want.verdict, o_result.verdict);
                check_field("write_enable", want.write_enable, o_result.write_enable);
                check_field("write_offset", want.write_offset, o_result.write_offset);
                check_field("write_length", want.write_length, o_result.write_length);
                check_field("newly_lost", want.newly_lost, o_result.newly_lost);
                check_field("remaining", want.remaining, o_result.remaining);
                check_field("complete", want.complete, o_result.complete);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving. All tasks are entered just after a rising edge and return
    // just after one, so every input sees one NBA per time step at most.
    // ------------------------------------------------------------------

    // Offers one transaction and waits for it to be taken. i_start is left
    // high when no gap follows, so back-to-back items never toggle it.
    task automatic send_item(input clt_pkg::t_item it);
        int unsigned gap;
        int unsigned roll;
        i_item  <= it;
        i_start <= 1'b1;
        do @(negedge i_clk); while (o_busy !== 1'b0);
        expected_results.push_back(track_chunk(it));
        @(posedge i_clk);
        gap = 0;
        if (!no_idle) begin
            roll = $urandom_range(0, 99);
            if (roll >= 90)
                gap = $urandom_range(4, 40);
            else if (roll >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drops start and waits until every result is in and the block is idle.
    task automatic wait_idle();
        i_start <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0 || o_busy !== 1'b0);
        @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges; block must be idle.
    task automatic load_regs(input logic [15:0] csize, input logic [12:0] total,
                             input logic [12:0] endseq);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= clt_pkg::REG_CHUNK_SIZE;
        i_cfg_data <= csize;
        @(posedge i_clk);
        cfg_chunk_size = csize;
        i_cfg_idx  <= clt_pkg::REG_TOTAL_CHUNKS;
        i_cfg_data <= {3'b0, total};
        @(posedge i_clk);
        cfg_total_chunks = total;
        i_cfg_idx  <= clt_pkg::REG_END_SEQUENCE;
        i_cfg_data <= {3'b0, endseq};
        @(posedge i_clk);
        cfg_end_sequence = endseq;
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset state: nothing outstanding, deadline disarmed, unused mode.
    task automatic test_before_start();
        wait_idle();
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd0, 16'd100));
        send_item(make_item(clt_pkg::MODE_DEADLINE, 32'd0, 16'd0));
        send_item(make_item(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF));
    endtask

    // Widest window, largest chunk size, sequence extremes and duplicates.
    task automatic test_extremes();
        wait_idle();
        load_regs(16'hFFFF, 13'd4096, 13'd4096);
        send_item(make_item(clt_pkg::MODE_START, 32'h0, 16'h0));
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd0, 16'hFFFF));
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd0, 16'hFFFF));     // repeat of latest
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd4095, 16'd0));     // whole bitmap skipped
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd4096, 16'd7));     // just past capacity
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd5, 16'h5555));     // recovery
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd5, 16'hAAAA));     // older duplicate
        send_item(make_item(clt_pkg::MODE_DEADLINE, 32'h0, 16'h0));     // empty tail
        send_item(make_item(clt_pkg::MODE_DEADLINE, 32'h0, 16'h0));     // already fired
    endtask

    // Tail marking with a zero bound and a real one, an ahead chunk already
    // marked by the tail, completion and the transfer-done cases.
    task automatic test_tail_marking();
        wait_idle();
        load_regs(16'd1, 13'd3, 13'd0);
        send_item(make_item(clt_pkg::MODE_START, 32'h0, 16'h0));
        send_item(make_item(clt_pkg::MODE_DEADLINE, 32'h0, 16'h0));
        wait_idle();
        load_regs(16'd1, 13'd3, 13'd20);
        send_item(make_item(clt_pkg::MODE_START, 32'h0, 16'h0));
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd2, 16'd10));
        send_item(make_item(clt_pkg::MODE_DEADLINE, 32'h0, 16'h0));
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd10, 16'd11));
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd0, 16'd12));       // last one: complete
        send_item(make_item(clt_pkg::MODE_CHUNK, 32'd1, 16'd13));
        wait_idle();
        load_regs(16'd40000, 13'd0, 13'd4096);
        send_item(make_item(clt_pkg::MODE_START, 32'h0, 16'h0));
        send_item(make_item(clt_pkg::MODE_DEADLINE, 32'h0, 16'h0));     // armed, none left
    endtask

    // One transfer: fresh settings, a start, then mostly well-formed traffic
    // (in order, small and large gaps, retransmits of lost chunks) with
    // duplicates, deadlines, out-of-range and raw noise mixed in.
    task automatic run_transfer();
        int unsigned    roll;
        int unsigned    csize;
        int unsigned    total;
        int unsigned    endseq;
        int unsigned    n_items;
        int unsigned    skip;
        int             lost_seq;
        clt_pkg::t_item it;
        roll  = $urandom_range(0, 9);
        csize = (roll == 0) ? 1 : (roll == 1) ? 16'hFFFF : $urandom_range(1, 16'hFFFF);
        roll  = $urandom_range(0, 19);
        total = (roll < 2) ? 0 : (roll == 2) ? clt_pkg::MAX_CHUNKS : $urandom_range(4, 80);
        roll  = $urandom_range(0, 9);
        if (roll == 0)
            endseq = 0;
        else if (roll == 1)
            endseq = clt_pkg::MAX_CHUNKS;
        else if (roll < 6)
            endseq = total;
        else
            endseq = $urandom_range(0, total + 100);
        if (endseq > clt_pkg::MAX_CHUNKS)
            endseq = clt_pkg::MAX_CHUNKS;
        n_items = (total > 80) ? 80 : $urandom_range(total / 2 + 5, total * 2 + 10);

        wait_idle();
        load_regs(csize[15:0], total[12:0], endseq[12:0]);
        no_idle = ($urandom_range(0, 3) == 0);
        send_item(make_item(clt_pkg::MODE_START, $urandom, 16'($urandom)));
        items_sent++;

        repeat (n_items) begin
            roll     = $urandom_range(0, 99);
            lost_seq = pick_lost();
            if (roll < 55) begin
                if (roll < 35)
                    skip = 0;
                else if (roll < 50)
                    skip = $urandom_range(1, 4);
                else
                    skip = $urandom_range(5, 300);
                it = make_item(clt_pkg::MODE_CHUNK, hi_next + skip, 16'($urandom));
            end else if (roll < 75 && lost_seq >= 0) begin
                it = make_item(clt_pkg::MODE_CHUNK, 32'(lost_seq), 16'($urandom));
            end else if (roll < 82) begin
                it = make_item(clt_pkg::MODE_CHUNK,
                               (hi_next == 0) ? 0 : $urandom_range(0, hi_next - 1),
                               16'($urandom));
            end else if (roll < 87) begin
                it = make_item(clt_pkg::MODE_DEADLINE, $urandom, 16'($urandom));
            end else if (roll < 91) begin
                it = make_item(clt_pkg::MODE_CHUNK,
                               $urandom_range(clt_pkg::MAX_CHUNKS, 32'hFFFF_FFFF),
                               16'($urandom));
            end else if (roll < 96) begin
                it = make_item(2'($urandom_range(0, 3)), $urandom, 16'($urandom));
            end else if (roll < 98) begin
                it = make_item(clt_pkg::MODE_START, $urandom, 16'($urandom));
            end else begin
                it = make_item(MODE_UNUSED, $urandom, 16'($urandom));
            end
            send_item(it);
            if (it.mode != MODE_UNUSED)
                items_sent++;
        end
    endtask

    task automatic test_random_transfers();
        while (items_sent < RANDOM_ITEMS)
            run_transfer();
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, the directed tests, the random part, drain.
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_before_start();
        test_extremes();
        test_tail_marking();
        test_random_transfers();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && expected_results.size() == 0)
            $display("** chunk_loss_tracker: PASSED **");
        else
            $display("** chunk_loss_tracker: FAILED **");
        $finish;
    end

endmodule
